// ----- design/quaternion_rate_estimator_top_macros.svh -----
// ----------------------------------------------------------------------------
// quaternion rate estimator assertion macros
// concurrent assertion helpers used by the checker file qre_check
// ----------------------------------------------------------------------------
`ifndef QUATERNION_RATE_ESTIMATOR_TOP_MACROS_SVH
`define QUATERNION_RATE_ESTIMATOR_TOP_MACROS_SVH

// checked only out of reset
`define QRE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define QRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- design/qre_pkg.sv -----
// ----------------------------------------------------------------------------
// qre_pkg
// types, widths and the product schedule of the quaternion rate estimator
// ----------------------------------------------------------------------------
package qre_pkg;

    localparam int QW        = 16;
    localparam int STAMP_W   = 32;
    localparam int TICK_W    = 27;
    localparam int RATE_W    = 32;
    localparam int ACC_W     = 34;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 28;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int NUM_SHIFT = 14;
    localparam int NUM_W     = 45;
    localparam int DIV_W     = 32;
    localparam int MAC_STEPS = 12;
    localparam int CNT_W     = 4;

    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 27'd1000000;
    localparam logic signed [QW-1:0] Q_ONE = 16'sd32767;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_ZERO = 2'd1;
    localparam status_t ST_SAT  = 2'd2;

    typedef logic [1:0] qidx_t;
    localparam qidx_t IDX_W = 2'd0;
    localparam qidx_t IDX_X = 2'd1;
    localparam qidx_t IDX_Y = 2'd2;
    localparam qidx_t IDX_Z = 2'd3;

    // one product of the relative rotation vector part
    typedef struct packed {
        qidx_t      qsel;
        qidx_t      psel;
        logic       neg;
        logic [1:0] comp;
    } mac_op_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } div_stat_t;

    // vector part of q * conj(p), four products per component
    function automatic mac_op_t mac_op(input logic [CNT_W-1:0] step);
        mac_op_t op;
        case (step)
            4'd0:    op = '{IDX_W, IDX_X, 1'b1, 2'd0};
            4'd1:    op = '{IDX_X, IDX_W, 1'b0, 2'd0};
            4'd2:    op = '{IDX_Y, IDX_Z, 1'b1, 2'd0};
            4'd3:    op = '{IDX_Z, IDX_Y, 1'b0, 2'd0};
            4'd4:    op = '{IDX_W, IDX_Y, 1'b1, 2'd1};
            4'd5:    op = '{IDX_X, IDX_Z, 1'b0, 2'd1};
            4'd6:    op = '{IDX_Y, IDX_W, 1'b0, 2'd1};
            4'd7:    op = '{IDX_Z, IDX_X, 1'b1, 2'd1};
            4'd8:    op = '{IDX_W, IDX_Z, 1'b1, 2'd2};
            4'd9:    op = '{IDX_X, IDX_Y, 1'b1, 2'd2};
            4'd10:   op = '{IDX_Y, IDX_X, 1'b0, 2'd2};
            4'd11:   op = '{IDX_Z, IDX_W, 1'b0, 2'd2};
            default: op = '{IDX_W, IDX_W, 1'b0, 2'd0};
        endcase
        return op;
    endfunction

endpackage

// ----- design/qre_mul.sv -----
// ----------------------------------------------------------------------------
// qre_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
module qre_mul (
    input  logic                                 clk,
    input  logic signed [qre_pkg::MUL_A_W-1:0]   a,
    input  logic signed [qre_pkg::MUL_B_W-1:0]   b,
    output logic signed [qre_pkg::PROD_W-1:0]    prod
);
    import qre_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ----- design/qre_div.sv -----
// ----------------------------------------------------------------------------
// qre_div
// radix-2 restoring divider, one quotient bit per cycle, 32-bit quotient
// ----------------------------------------------------------------------------
module qre_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qre_pkg::NUM_W-1:0]     dividend,
    input  logic [qre_pkg::DIV_W-1:0]     divisor,
    output logic [qre_pkg::DIV_W-1:0]     quo,
    output qre_pkg::div_stat_t            stat
);
    import qre_pkg::*;

    localparam int HI_W    = NUM_W - DIV_W;
    localparam int STEP_CW = $clog2(DIV_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               ovf_reg, ovf_next;
    logic [STEP_CW-1:0] step_reg, step_next;
    logic [DIV_W-1:0]   rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DIV_W-1:0]   div_reg, div_next;
    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        ovf_next  = ovf_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, div_reg};
        if (start)
        begin
            div_next = divisor;
            rem_next = DIV_W'(dividend[NUM_W-1:DIV_W]);
            quo_next = dividend[DIV_W-1:0];
            // quotient needs more than 32 bits
            if ({{(DIV_W-HI_W){1'b0}}, dividend[NUM_W-1:DIV_W]} >= divisor)
            begin
                ovf_next  = 1'b1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                ovf_next  = 1'b0;
                busy_next = 1'b1;
                step_next = STEP_CW'(DIV_W);
            end
        end
        else if (busy_reg)
        begin
            if (!trial[DIV_W])
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg <= ovf_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

// ----- design/quaternion_rate_estimator_top.sv -----
// ----------------------------------------------------------------------------
// quaternion_rate_estimator_top
// angular rate from the difference of two timestamped orientation quaternions
// ----------------------------------------------------------------------------
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | tdata: quat_w, quat_x, quat_y, quat_z, stamp
//  m_axis   | out | tdata: rate_x, rate_y, rate_z; tuser: status
//  cfg      | in  | cfg_data: tick_rate, always ready
//
//  an input beat runs the twelve products on the shared multiplier, then per
//  component a clamp, a scale multiply, the serial divider (cut short when the
//  quotient overflows) and a result step, then loads the result register; a zero
//  interval skips the per-component steps and goes straight to the result load.
//  s_axis_tready is high only in idle; a result waiting on m_axis does not
//  block the next input, but the following result waits for the register.
//  reset restores the identity quaternion, time zero and tick_rate 1000000.
// ----------------------------------------------------------------------------
module quaternion_rate_estimator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48], stamp[95:64]
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,
    // rate_x[31:0], rate_y[63:32], rate_z[95:64]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [95:0]                   m_axis_tdata,
    // status[1:0]
    output logic [1:0]                    m_axis_tuser,
    // tick_rate, ticks per second
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [qre_pkg::TICK_W-1:0]    cfg_data
);
    import qre_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MAC   = 7'b0000010,
        S_CLAMP = 7'b0000100,
        S_MULW  = 7'b0001000,
        S_DIVW  = 7'b0010000,
        S_RES   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 34'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -34'sd2147483648;
    localparam logic [RATE_W-1:0] RATE_MAX = 32'h7FFF_FFFF;
    localparam logic [RATE_W-1:0] RATE_MIN = 32'h8000_0000;

    // control
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [1:0]          comp_reg, comp_next;
    logic                out_valid_reg, out_valid_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    // stored previous sample
    logic signed [QW-1:0] p_reg [4];
    logic signed [QW-1:0] p_next [4];
    logic [STAMP_W-1:0]  last_stamp_reg, last_stamp_next;
    // working payload
    logic signed [QW-1:0] q_reg [4];
    logic signed [QW-1:0] q_next [4];
    logic [STAMP_W-1:0]  dt_reg, dt_next;
    logic signed [ACC_W-1:0] acc_reg [3];
    logic signed [ACC_W-1:0] acc_next [3];
    logic [RATE_W-1:0]   res_reg [3];
    logic [RATE_W-1:0]   res_next [3];
    logic                neg_reg, neg_next;
    logic                sat_reg, sat_next;
    logic [DIV_W-1:0]    quo_hold_reg, quo_hold_next;
    logic                ovf_hold_reg, ovf_hold_next;
    logic [95:0]         out_data_reg, out_data_next;
    status_t             out_user_reg, out_user_next;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic                      div_start;
    logic [DIV_W-1:0]          div_quo;
    div_stat_t                 div_stat;

    // datapath helpers
    mac_op_t                 op_issue;
    mac_op_t                 op_acc;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] v_sel;
    logic [RATE_W-1:0]       v_clamp;
    logic                    v_sat;
    logic [RATE_W-1:0]       mag;
    logic                    in_fire;

    qre_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // numerator is mag * tick_rate >> 14, divisor is the interval
    qre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod[NUM_SHIFT+NUM_W-1:NUM_SHIFT]),
        .divisor  (dt_reg),
        .quo      (div_quo),
        .stat     (div_stat)
    );

    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign op_issue = mac_op(cnt_reg);
    assign op_acc   = mac_op(cnt_reg - 1'b1);
    // a 16x16 product fits the accumulator width, upper bits are sign copies
    assign term     = $signed(prod[ACC_W-1:0]);

    // clamp the selected vector component to 32 bits, then take magnitude
    always_comb
    begin
        v_sel = acc_reg[comp_reg];
        v_sat = 1'b0;
        if (v_sel > ACC_MAX)
        begin
            v_clamp = RATE_MAX;
            v_sat   = 1'b1;
        end
        else if (v_sel < ACC_MIN)
        begin
            v_clamp = RATE_MIN;
            v_sat   = 1'b1;
        end
        else
        begin
            v_clamp = v_sel[RATE_W-1:0];
        end
        mag = v_clamp[RATE_W-1] ? (RATE_W'(0) - v_clamp) : v_clamp;
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_MAC)
        begin
            mul_a = {{(MUL_A_W-QW){q_reg[op_issue.qsel][QW-1]}}, q_reg[op_issue.qsel]};
            mul_b = {{(MUL_B_W-QW){p_reg[op_issue.psel][QW-1]}}, p_reg[op_issue.psel]};
        end
        else if (state_reg == S_CLAMP)
        begin
            mul_a = {1'b0, mag};
            mul_b = {1'b0, tick_reg};
        end
    end

    assign div_start = (state_reg == S_MULW);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        comp_next       = comp_reg;
        out_valid_next  = out_valid_reg;
        tick_next       = tick_reg;
        p_next          = p_reg;
        last_stamp_next = last_stamp_reg;
        q_next          = q_reg;
        dt_next         = dt_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        neg_next        = neg_reg;
        sat_next        = sat_reg;
        quo_hold_next   = quo_hold_reg;
        ovf_hold_next   = ovf_hold_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;

        if (cfg_valid && cfg_ready)
        begin
            tick_next = cfg_data;
        end

        if (m_axis_tvalid && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    q_next[IDX_W]   = $signed(s_axis_tdata[15:0]);
                    q_next[IDX_X]   = $signed(s_axis_tdata[31:16]);
                    q_next[IDX_Y]   = $signed(s_axis_tdata[47:32]);
                    q_next[IDX_Z]   = $signed(s_axis_tdata[63:48]);
                    dt_next         = s_axis_tdata[95:64] - last_stamp_reg;
                    last_stamp_next = s_axis_tdata[95:64];
                    for (int k = 0; k < 3; k++)
                    begin
                        acc_next[k] = '0;
                        res_next[k] = '0;
                    end
                    sat_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                // product of the previous step lands in the cycle after its issue
                if (cnt_reg != '0)
                begin
                    acc_next[op_acc.comp] = op_acc.neg ? acc_reg[op_acc.comp] - term
                                                       : acc_reg[op_acc.comp] + term;
                end
                if (cnt_reg == CNT_W'(MAC_STEPS))
                begin
                    comp_next  = 2'd0;
                    state_next = (dt_reg == '0) ? S_DONE : S_CLAMP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CLAMP:
            begin
                neg_next   = v_clamp[RATE_W-1];
                sat_next   = sat_reg | v_sat;
                state_next = S_MULW;
            end
            S_MULW:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    quo_hold_next = div_quo;
                    ovf_hold_next = div_stat.ovf;
                    state_next    = S_RES;
                end
            end
            S_RES:
            begin
                if (!neg_reg)
                begin
                    if (ovf_hold_reg || quo_hold_reg[RATE_W-1])
                    begin
                        res_next[comp_reg] = RATE_MAX;
                        sat_next           = 1'b1;
                    end
                    else
                    begin
                        res_next[comp_reg] = quo_hold_reg;
                    end
                end
                else
                begin
                    if (ovf_hold_reg || quo_hold_reg > RATE_MIN)
                    begin
                        res_next[comp_reg] = RATE_MIN;
                        sat_next           = 1'b1;
                    end
                    else
                    begin
                        res_next[comp_reg] = RATE_W'(0) - quo_hold_reg;
                    end
                end
                if (comp_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = S_CLAMP;
                end
            end
            S_DONE:
            begin
                // output register free or draining this cycle
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_reg[2], res_reg[1], res_reg[0]};
                    if (dt_reg == '0)
                    begin
                        out_user_next = ST_ZERO;
                    end
                    else if (sat_reg)
                    begin
                        out_user_next = ST_SAT;
                    end
                    else
                    begin
                        out_user_next = ST_OK;
                    end
                    p_next     = q_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            comp_reg       <= '0;
            out_valid_reg  <= 1'b0;
            tick_reg       <= TICK_RATE_RESET;
            p_reg[IDX_W]   <= Q_ONE;
            p_reg[IDX_X]   <= '0;
            p_reg[IDX_Y]   <= '0;
            p_reg[IDX_Z]   <= '0;
            last_stamp_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            comp_reg       <= comp_next;
            out_valid_reg  <= out_valid_next;
            tick_reg       <= tick_next;
            p_reg          <= p_next;
            last_stamp_reg <= last_stamp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        dt_reg       <= dt_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        neg_reg      <= neg_next;
        sat_reg      <= sat_next;
        quo_hold_reg <= quo_hold_next;
        ovf_hold_reg <= ovf_hold_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign cfg_ready     = 1'b1;

endmodule

// ----- design/qre_check.sv -----
// ----------------------------------------------------------------------------
// qre_check
// port-level checks of the quaternion rate estimator, bound to the top level
// ----------------------------------------------------------------------------
`include "quaternion_rate_estimator_top_macros.svh"

module qre_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    import qre_pkg::*;

    // a stalled result beat holds
    `QRE_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")

    // one item at a time: busy right after an input beat
    `QRE_ASSERT(a_busy_after_in, clk, rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted while busy")

    // zero interval gives zero rates
    `QRE_ASSERT(a_zero_rates, clk, rst_n, m_axis_tvalid && m_axis_tuser == ST_ZERO |-> m_axis_tdata == '0 && m_axis_tuser != 2'd3, "zero interval with nonzero rate")

    // reset leaves no result and an idle input side
    `QRE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !m_axis_tvalid && s_axis_tready, "not idle after reset")

endmodule

bind quaternion_rate_estimator_top qre_check u_qre_check (.*);
